// ===== hw/rtl/fdf_pkg.sv =====
// Package for the forward difference filter: payload structs, controller and
// datapath command/status structs, register map and fixed-point constants.
// No dependencies.
`default_nettype none

package fdf_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_BITS   = 16;
   localparam int ORDER_WIDTH   = 4;
   localparam int SCALE_WIDTH   = 24;
   localparam int RESULT_WIDTH  = 32;

   // Default deepest order
   localparam int MAX_ORDER_DEF = 8;

   // Scale is applied one byte per cycle, most significant byte first
   localparam int SCALE_CHUNK   = 8;
   localparam int SCALE_CHUNKS  = SCALE_WIDTH / SCALE_CHUNK;
   localparam int CHUNK_IDX_W   = (SCALE_CHUNKS > 1) ? $clog2(SCALE_CHUNKS) : 1;

   // Q8.16 scale: fraction bits dropped, with round half up
   localparam int FRAC_BITS     = 16;
   localparam int ROUND_HALF    = 1 << (FRAC_BITS - 1);

   // Register map
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REG_IDX_W     = 1;
   localparam logic [REG_IDX_W-1:0] REG_DIFF_ORDER = 1'd0;
   localparam logic [REG_IDX_W-1:0] REG_STEP_SCALE = 1'd1;

   localparam logic [ORDER_WIDTH-1:0] DIFF_ORDER_RST = 4'd1;
   localparam logic [SCALE_WIDTH-1:0] STEP_SCALE_RST = 24'd65536;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] difference;
      logic                           last_result;
      logic                           too_short;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic                   accept;
      logic                   pass;
      logic                   mul;
      logic                   mul_first;
      logic [CHUNK_IDX_W-1:0] chunk_idx;
      logic                   emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic want_diff;
      logic want_short;
      logic pass_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/forward_difference_filter.sv =====
// Forward difference filter, top level: register block, sequencer, datapath.
// Depends on fdf_pkg, fdf_ctrl, fdf_datapath.
//
// Usage:
//  - req channel: one signed sample per beat, last_sample closes a vector.
//  - rsp channel: at most one result per sample; difference is the order-d
//    forward difference over the newest d+1 samples times step_scale (Q8.16),
//    rounded half up and saturated to 32 bits. last_result follows the
//    sample's last flag; too_short marks a vector that ended with d or fewer
//    samples (difference 0).
//  - The first d samples of a vector give no result, but for the too_short
//    result of a vector that ends there. A producing sample runs d difference
//    passes, then three byte steps of the scale multiply, then loads the
//    output register; the next sample is taken only after that load. A
//    too_short result skips the passes and the multiply.
//  - The output register holds a result while rsp_stall is high; the next
//    sample is still accepted, and the block waits only when a new result
//    is ready while the old one has not been taken.
//  - Reset clears the fill count and output valid and sets diff_order to 1,
//    step_scale to 1.0. Write the registers only while the block is idle.
`default_nettype none

module forward_difference_filter #(
   parameter int MAX_ORDER = fdf_pkg::MAX_ORDER_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // input channel
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  fdf_pkg::req_payload_type            req_payload,
   // result channel
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output fdf_pkg::rsp_payload_type            rsp_payload,
   // register port
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [fdf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [fdf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fdf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [fdf_pkg::ORDER_WIDTH-1:0]  diff_order_ff;
   logic [fdf_pkg::SCALE_WIDTH-1:0]  step_scale_ff;
   logic [fdf_pkg::REG_IDX_W-1:0]    reg_idx;
   logic                             csr_wr;
   fdf_pkg::cmd_type                 cmd;
   fdf_pkg::status_type              status;

   // Register block
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[fdf_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_order_ff <= fdf_pkg::DIFF_ORDER_RST;
         step_scale_ff <= fdf_pkg::STEP_SCALE_RST;
      end else if (csr_wr) begin
         unique case (reg_idx)
            fdf_pkg::REG_DIFF_ORDER:
               diff_order_ff <= csr_pwdata[fdf_pkg::ORDER_WIDTH-1:0];
            fdf_pkg::REG_STEP_SCALE:
               step_scale_ff <= csr_pwdata[fdf_pkg::SCALE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         fdf_pkg::REG_DIFF_ORDER:
            csr_prdata = fdf_pkg::CSR_DATA_W'(diff_order_ff);
         fdf_pkg::REG_STEP_SCALE:
            csr_prdata = fdf_pkg::CSR_DATA_W'(step_scale_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   fdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fdf_datapath #(
      .MAX_ORDER (MAX_ORDER)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .diff_order  (diff_order_ff),
      .step_scale  (step_scale_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/fdf_ctrl.sv =====
// Sequencer for the forward difference filter: accepts a beat, then runs the
// difference passes, the byte-serial scale and the result load; a too_short beat gets only the load.
// Depends on fdf_pkg.
`default_nettype none

module fdf_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  fdf_pkg::status_type  status,
   output fdf_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIFF = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                           state_ff, state_in;
   logic [fdf_pkg::CHUNK_IDX_W-1:0]     chunk_ff, chunk_in;

   localparam logic [fdf_pkg::CHUNK_IDX_W-1:0] CHUNK_LAST =
      fdf_pkg::CHUNK_IDX_W'(fdf_pkg::SCALE_CHUNKS - 1);

   // Input is taken only between items
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      chunk_in      = chunk_ff;
      cmd           = '0;
      cmd.chunk_idx = chunk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.want_diff) begin
                  state_in = ST_DIFF;
               end else if (status.want_short) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIFF: begin
            cmd.pass = 1'b1;
            if (status.pass_last) begin
               state_in = ST_MUL;
               chunk_in = '0;
            end
         end
         ST_MUL: begin
            cmd.mul       = 1'b1;
            cmd.mul_first = (chunk_ff == '0);
            if (chunk_ff == CHUNK_LAST) begin
               state_in = ST_EMIT;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chunk_ff <= '0;
      end else begin
         state_ff <= state_in;
         chunk_ff <= chunk_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fdf_datapath.sv =====
// Datapath of the forward difference filter: sample history, fill count,
// difference passes, byte-serial scaling, rounding, saturation, result register.
// Depends on fdf_pkg.
`default_nettype none

module fdf_datapath #(
   parameter int MAX_ORDER = fdf_pkg::MAX_ORDER_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  fdf_pkg::req_payload_type              req_payload,
   input  wire  [fdf_pkg::ORDER_WIDTH-1:0]       diff_order,
   input  wire  [fdf_pkg::SCALE_WIDTH-1:0]       step_scale,
   input  fdf_pkg::cmd_type                      cmd,
   output fdf_pkg::status_type                   status,
   input  wire                                   rsp_stall,
   output logic                                  rsp_valid,
   output fdf_pkg::rsp_payload_type              rsp_payload
);

   localparam int ORDER_W = $clog2(MAX_ORDER + 1);
   localparam int CMP_W   = (ORDER_W > fdf_pkg::ORDER_WIDTH) ? ORDER_W : fdf_pkg::ORDER_WIDTH;
   localparam int SUM_W   = fdf_pkg::SAMPLE_BITS + MAX_ORDER;
   localparam int ACC_W   = SUM_W + fdf_pkg::SCALE_WIDTH;
   localparam int PROD_W  = SUM_W + fdf_pkg::SCALE_CHUNK + 1;
   localparam int Q_W     = ACC_W - fdf_pkg::FRAC_BITS;
   localparam int X_W     = (Q_W > fdf_pkg::RESULT_WIDTH) ? Q_W : fdf_pkg::RESULT_WIDTH;

   localparam logic signed [fdf_pkg::RESULT_WIDTH-1:0] RES_MAX =
      {1'b0, {(fdf_pkg::RESULT_WIDTH-1){1'b1}}};
   localparam logic signed [fdf_pkg::RESULT_WIDTH-1:0] RES_MIN =
      {1'b1, {(fdf_pkg::RESULT_WIDTH-1){1'b0}}};
   localparam logic signed [X_W-1:0] X_MAX = X_W'(RES_MAX);
   localparam logic signed [X_W-1:0] X_MIN = X_W'(RES_MIN);

   logic signed [fdf_pkg::SAMPLE_BITS-1:0] hist_ff [MAX_ORDER];
   logic signed [SUM_W-1:0]                work_ff [MAX_ORDER+1];
   logic [ORDER_W-1:0]                     fill_ff;
   logic [ORDER_W-1:0]                     pass_cnt_ff;
   logic signed [ACC_W-1:0]                acc_ff, acc_in;
   logic                                   last_ff;
   logic                                   short_ff;
   logic                                   rsp_valid_ff;
   fdf_pkg::rsp_payload_type               rsp_data_ff;

   logic [CMP_W-1:0]                       ord_x;
   logic [ORDER_W-1:0]                     eff_order;
   logic [fdf_pkg::CHUNK_IDX_W-1:0]        byte_sel;
   logic signed [fdf_pkg::SCALE_CHUNK:0]   scale_byte;
   logic signed [PROD_W-1:0]               prod;
   logic signed [ACC_W-1:0]                rnd;
   logic signed [Q_W-1:0]                  q;
   logic signed [X_W-1:0]                  q_x;
   logic signed [fdf_pkg::RESULT_WIDTH-1:0] sat;

   // Order in force: zero acts as one, above the maximum clips
   always_comb begin
      ord_x = CMP_W'(diff_order);
      if (ord_x == '0) begin
         eff_order = ORDER_W'(1);
      end else if (ord_x > CMP_W'(MAX_ORDER)) begin
         eff_order = ORDER_W'(MAX_ORDER);
      end else begin
         eff_order = ORDER_W'(ord_x);
      end
   end

   // Status to the sequencer
   assign status.want_diff  = (fill_ff >= eff_order);
   assign status.want_short = req_payload.last_sample & ~(fill_ff >= eff_order);
   assign status.pass_last  = (pass_cnt_ff == ORDER_W'(1));
   assign status.out_free   = ~rsp_valid_ff | ~rsp_stall;

   // One scale byte per cycle, top byte first
   assign byte_sel   = fdf_pkg::CHUNK_IDX_W'(fdf_pkg::SCALE_CHUNKS - 1) - cmd.chunk_idx;
   assign scale_byte = $signed({1'b0, step_scale[fdf_pkg::SCALE_CHUNK*byte_sel +:
                                                 fdf_pkg::SCALE_CHUNK]});
   assign prod       = work_ff[0] * scale_byte;

   always_comb begin
      if (cmd.mul_first) begin
         acc_in = ACC_W'(prod);
      end else begin
         acc_in = (acc_ff <<< fdf_pkg::SCALE_CHUNK) + ACC_W'(prod);
      end
   end

   // Round half up, drop fraction, saturate
   assign rnd = acc_ff + ACC_W'(fdf_pkg::ROUND_HALF);
   assign q   = Q_W'(rnd >>> fdf_pkg::FRAC_BITS);
   assign q_x = X_W'(q);

   always_comb begin
      priority if (q_x > X_MAX) begin
         sat = RES_MAX;
      end else if (q_x < X_MIN) begin
         sat = RES_MIN;
      end else begin
         sat = fdf_pkg::RESULT_WIDTH'(q_x);
      end
   end

   // History, working row and scale accumulator
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         work_ff[0] <= SUM_W'(req_payload.sample);
         for (int i = 1; i <= MAX_ORDER; i++) begin
            work_ff[i] <= SUM_W'(hist_ff[i-1]);
         end
         hist_ff[0] <= req_payload.sample;
         for (int i = 1; i < MAX_ORDER; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
         pass_cnt_ff <= eff_order;
         last_ff     <= req_payload.last_sample;
         short_ff    <= ~status.want_diff;
      end else if (cmd.pass) begin
         // one difference pass over the row
         for (int i = 0; i < MAX_ORDER; i++) begin
            work_ff[i] <= work_ff[i] - work_ff[i+1];
         end
         pass_cnt_ff <= pass_cnt_ff - 1'b1;
      end
      if (cmd.mul) begin
         acc_ff <= acc_in;
      end
      if (cmd.emit) begin
         rsp_data_ff.difference  <= short_ff ? '0 : sat;
         rsp_data_ff.last_result <= last_ff;
         rsp_data_ff.too_short   <= short_ff;
      end
   end

   // Fill count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (req_payload.last_sample) begin
               fill_ff <= '0;
            end else if (fill_ff < ORDER_W'(MAX_ORDER)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for forward_difference_filter: directed table then random vectors,
// each result checked against a typed table value or a built-in fixed-point difference predictor.
// Depends on fdf_pkg and the forward_difference_filter RTL.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ORDER    = fdf_pkg::MAX_ORDER_DEF;
   localparam int SEGMENTS     = 8;
   localparam int SEG_SAMPLES  = 220;
   localparam int SETTLE_WAIT  = 3 * MAX_ORDER;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [fdf_pkg::ORDER_WIDTH-1:0] order;
      logic [fdf_pkg::SCALE_WIDTH-1:0] scale;
      fdf_pkg::req_payload_type        beat;
      bit                              typed;
      fdf_pkg::rsp_payload_type        want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   fdf_pkg::req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   fdf_pkg::rsp_payload_type rsp_payload;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [fdf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [fdf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [fdf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // predictor copy of the block state and registers
   logic signed [fdf_pkg::SAMPLE_BITS-1:0] past_samples [MAX_ORDER];
   int                                     held_count;
   logic [fdf_pkg::ORDER_WIDTH-1:0]        order_reg;
   logic [fdf_pkg::SCALE_WIDTH-1:0]        scale_reg;

   fdf_pkg::rsp_payload_type expected_results [$];
   stim_row_type             directed_rows [$];
   fdf_pkg::rsp_payload_type predicted;
   fdf_pkg::rsp_payload_type oldest;
   bit                       typed_flag;
   fdf_pkg::rsp_payload_type typed_result;
   int                       send_idle_pct;
   int                       recv_stall_pct;
   int                       mismatch_count;
   int                       cycle_count;

   forward_difference_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one sample step of the predictor; returns 1 when the sample yields a result
   function automatic bit difference_step(input fdf_pkg::req_payload_type beat,
                                          output fdf_pkg::rsp_payload_type result);
      int     d;
      int     k;
      longint acc;
      longint coeff;
      longint whole;
      longint frac;
      longint total;
      bit     produced;
      d = int'(order_reg);
      if (d == 0) d = 1;
      if (d > MAX_ORDER) d = MAX_ORDER;
      produced = 1'b0;
      result = '0;
      if (held_count >= d) begin
         // binomial taps with alternating sign over the newest d+1 samples
         acc = longint'(beat.sample);
         coeff = 1;
         for (k = 1; k <= d; k++) begin
            coeff = coeff * longint'(d - k + 1) / longint'(k);
            if (k % 2 == 1) acc = acc - coeff * longint'(past_samples[k-1]);
            else acc = acc + coeff * longint'(past_samples[k-1]);
         end
         // Q8.16 scale, round half up, then saturate
         whole = acc * longint'(scale_reg[fdf_pkg::SCALE_WIDTH-1:fdf_pkg::FRAC_BITS]);
         frac = (acc * longint'(scale_reg[fdf_pkg::FRAC_BITS-1:0]) +
                 longint'(fdf_pkg::ROUND_HALF)) >>> fdf_pkg::FRAC_BITS;
         total = whole + frac;
         if (total > 64'sd2147483647) total = 64'sd2147483647;
         if (total < -64'sd2147483648) total = -64'sd2147483648;
         result.difference = total[fdf_pkg::RESULT_WIDTH-1:0];
         result.last_result = beat.last_sample;
         result.too_short = 1'b0;
         produced = 1'b1;
      end else if (beat.last_sample) begin
         result.last_result = 1'b1;
         result.too_short = 1'b1;
         produced = 1'b1;
      end
      for (k = MAX_ORDER - 1; k > 0; k--) past_samples[k] = past_samples[k-1];
      past_samples[0] = beat.sample;
      if (beat.last_sample) held_count = 0;
      else if (held_count < MAX_ORDER) held_count++;
      return produced;
   endfunction

   function automatic void flag_error(input string msg);
      if (mismatch_count < REPORT_LIMIT) $display("%s", msg);
      mismatch_count++;
   endfunction

   function automatic void add_row(input int order, input int scale, input int sample,
                                   input bit last, input bit typed, input int diff,
                                   input bit last_res, input bit short_vec);
      stim_row_type row;
      row.order = order[fdf_pkg::ORDER_WIDTH-1:0];
      row.scale = scale[fdf_pkg::SCALE_WIDTH-1:0];
      row.beat.sample = sample[fdf_pkg::SAMPLE_BITS-1:0];
      row.beat.last_sample = last;
      row.typed = typed;
      row.want.difference = diff;
      row.want.last_result = last_res;
      row.want.too_short = short_vec;
      directed_rows.push_back(row);
   endfunction

   // present one beat, with random idle cycles ahead of it, and wait until taken
   task automatic send_sample(input fdf_pkg::req_payload_type beat, input bit typed,
                              input fdf_pkg::rsp_payload_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      typed_flag <= typed;
      typed_result <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off the sender until every result is back and the block has gone quiet
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // register write followed by a read back of the same register
   task automatic csr_write_check(input logic [fdf_pkg::REG_IDX_W-1:0] index,
                                  input logic [31:0] value);
      logic [31:0] mask;
      mask = (index == fdf_pkg::REG_DIFF_ORDER) ? (32'd1 << fdf_pkg::ORDER_WIDTH) - 1
                                                : (32'd1 << fdf_pkg::SCALE_WIDTH) - 1;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == fdf_pkg::REG_DIFF_ORDER) order_reg = value[fdf_pkg::ORDER_WIDTH-1:0];
      else scale_reg = value[fdf_pkg::SCALE_WIDTH-1:0];
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) !== (value & mask))
         flag_error($sformatf("register %0d read back %h, written %h", index, csr_prdata, value));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic reconfigure(input logic [fdf_pkg::ORDER_WIDTH-1:0] order,
                              input logic [fdf_pkg::SCALE_WIDTH-1:0] scale);
      settle_block();
      if (order != order_reg) csr_write_check(fdf_pkg::REG_DIFF_ORDER, 32'(order));
      if (scale != scale_reg) csr_write_check(fdf_pkg::REG_STEP_SCALE, 32'(scale));
   endtask

   // receiver stall
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // predict on every accepted sample beat, check every accepted result beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (difference_step(req_payload, predicted))
               expected_results.push_back(typed_flag ? typed_result : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               flag_error($sformatf("unexpected result: diff %0d last %0b short %0b",
                  rsp_payload.difference, rsp_payload.last_result, rsp_payload.too_short));
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_payload.difference !== oldest.difference ||
                   rsp_payload.last_result !== oldest.last_result ||
                   rsp_payload.too_short !== oldest.too_short)
                  flag_error($sformatf({"mismatch: expected diff %0d last %0b short %0b,",
                                        " got diff %0d last %0b short %0b"},
                     oldest.difference, oldest.last_result, oldest.too_short,
                     rsp_payload.difference, rsp_payload.last_result, rsp_payload.too_short));
            end
         end
      end
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int seg;
      int n;
      int vec_left;
      int d_eff;
      int roll;
      int len;
      fdf_pkg::req_payload_type beat;
      fdf_pkg::rsp_payload_type no_want;
      logic [fdf_pkg::ORDER_WIDTH-1:0] next_order;
      logic [fdf_pkg::SCALE_WIDTH-1:0] next_scale;

      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      typed_flag = 1'b0;
      typed_result = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      cycle_count = 0;
      held_count = 0;
      order_reg = fdf_pkg::DIFF_ORDER_RST;
      scale_reg = fdf_pkg::STEP_SCALE_RST;
      foreach (past_samples[i]) past_samples[i] = '0;
      no_want = '0;
      vec_left = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: order, scale, sample, last, typed, diff, last_result, too_short
      // reset settings: warm-up sample then full-scale steps
      add_row(1, 65536, 100, 0, 0, 0, 0, 0);
      add_row(1, 65536, 32767, 0, 1, 32667, 0, 0);
      add_row(1, 65536, -32768, 1, 1, -65535, 1, 0);
      // one-sample vector is too short
      add_row(1, 65536, 5, 1, 1, 0, 1, 1);
      // order zero behaves as order one; half scale rounds a tie upward
      add_row(0, 32768, 10, 0, 0, 0, 0, 0);
      add_row(0, 32768, -7, 1, 0, 0, 0, 0);
      // deepest order, largest scale, alternating full-scale samples
      for (int i = 0; i < 10; i++)
         add_row(8, 24'hFFFFFF, (i % 2 == 0) ? 32767 : -32768, i == 9, 0, 0, 0, 0);
      // order above the maximum, zero scale, vector too short
      add_row(15, 0, 1, 0, 0, 0, 0, 0);
      add_row(15, 0, 2, 1, 1, 0, 1, 1);
      // order changed in the middle of a vector
      add_row(2, 65536, 3, 0, 0, 0, 0, 0);
      add_row(2, 65536, 9, 0, 0, 0, 0, 0);
      add_row(1, 65536, 4, 0, 0, 0, 0, 0);
      add_row(4, 65536, 1, 1, 1, 0, 1, 1);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].order != order_reg || directed_rows[i].scale != scale_reg)
            reconfigure(directed_rows[i].order, directed_rows[i].scale);
         send_sample(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      end

      // random segments, each with its own settings and idle pattern
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: begin
               next_order = 4'd8;
               next_scale = 24'hFFFFFF;
            end
            1: begin
               next_order = 4'd1;
               next_scale = 24'd0;
            end
            2: begin
               next_order = 4'd0;
               next_scale = 24'd1;
            end
            3: begin
               next_order = 4'd15;
               next_scale = 24'd65536;
            end
            default: begin
               next_order = 4'($urandom_range(0, 15));
               next_scale = ($urandom_range(1) == 1) ? 24'($urandom_range(0, 24'hFFFFFF))
                                                     : 24'($urandom_range(0, 24'h02FFFF));
            end
         endcase
         // vectors left open here carry across the order change
         reconfigure(next_order, next_scale);
         send_idle_pct = 0;
         recv_stall_pct = 0;
         case (seg % 4)
            1: send_idle_pct = 68;
            2: recv_stall_pct = 68;
            3: begin
               send_idle_pct = 31;
               recv_stall_pct = 31;
            end
            default: ;
         endcase

         for (n = 0; n < SEG_SAMPLES; n++) begin
            if (vec_left == 0) begin
               d_eff = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
               roll = $urandom_range(99);
               if (roll < 10) len = $urandom_range(1, d_eff);
               else if (roll < 85) len = $urandom_range(d_eff + 1, d_eff + 16);
               else len = $urandom_range(d_eff + 17, 60);
               vec_left = len;
            end
            roll = $urandom_range(99);
            if (roll < 12) beat.sample = ($urandom_range(1) == 1) ? 16'sh7FFF : 16'sh8000;
            else if (roll < 22) beat.sample = 16'($urandom_range(0, 15) - 8);
            else beat.sample = 16'($urandom);
            beat.last_sample = (vec_left == 1);
            vec_left--;
            send_sample(beat, 1'b0, no_want);
         end
      end

      // wait for every result, then for stray beats
      settle_block();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
